[sv/gn3d_pkg.sv]
package gn3d_pkg;

    localparam int TABLE_AW = 8;
    localparam int TABLE_SIZE = 1 << TABLE_AW;

    localparam logic [1:0] OP_EVAL = 2'd0;
    localparam logic [1:0] OP_PERM = 2'd1;
    localparam logic [1:0] OP_GRAD = 2'd2;

    localparam logic [1:0] REG_OCTAVES = 2'd0;
    localparam logic [1:0] REG_LACUNARITY = 2'd1;
    localparam logic [1:0] REG_PERSISTENCE = 2'd2;

    localparam logic [3:0] MAX_OCTAVES = 4'd8;
    localparam logic [3:0] RST_OCTAVES = 4'd4;
    localparam logic [15:0] RST_LACUNARITY = 16'd8192;
    localparam logic [15:0] RST_PERSISTENCE = 16'd32768;

    localparam logic signed [31:0] NOISE_MAX = 32'sd1048575;
    localparam logic signed [31:0] NOISE_MIN = -32'sd1048576;

    typedef logic signed [35:0] mul_a_t;
    typedef logic signed [25:0] mul_b_t;
    typedef logic signed [61:0] prod_t;

    function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0)
        begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

endpackage

[sv/gradient_noise_3d_octaves_core.sv]
// Fractal 3-D gradient noise engine.
// Requests enter on the input channel (in_valid/in_stall) and results leave
// on the output channel (out_valid/out_stall); a transfer happens when valid
// is high and stall is low. Op 0 evaluates noise at a Q8.16 point, op 1 loads
// a permutation entry and op 2 loads a gradient entry; every request yields
// exactly one result, in order.
// Load requests write the table in the accept cycle and present their
// acknowledgment on the following cycle. An evaluation runs on one shared
// multiplier under a sequencer which, for each octave, scales the point, forms
// the six axis weights, visits each lattice corner and adds the octave sum;
// it runs octave_count octaves (octave_count capped at 8) and then presents
// the result.
// One request is in work at a time; the next request is taken
// once the sequencer is idle and the output register is free or being read.
// A stalled result holds in the output register and blocks further requests.
// Reset clears the sequencer and output valid and loads the register defaults
// (4 octaves, lacunarity 2.0, persistence 0.5). The tables are not cleared and
// must be loaded before use. Registers must be written through
// cfg_valid/cfg_ready only while the block is idle, which it does not enforce.
module gradient_noise_3d_octaves_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [23:0]        coord_x,
    input  logic [23:0]        coord_y,
    input  logic [23:0]        coord_z,
    input  logic [7:0]         entry_index,
    input  logic [7:0]         perm_value,
    input  logic signed [15:0] grad_x,
    input  logic signed [15:0] grad_y,
    input  logic signed [15:0] grad_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [20:0] noise_value,
    output logic               is_noise,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_PMUL = 5'd1;
    localparam logic [4:0] ST_PSAV = 5'd2;
    localparam logic [4:0] ST_WSQ  = 5'd3;
    localparam logic [4:0] ST_WA2  = 5'd4;
    localparam logic [4:0] ST_WCUB = 5'd5;
    localparam logic [4:0] ST_WSAV = 5'd6;
    localparam logic [4:0] ST_H0   = 5'd7;
    localparam logic [4:0] ST_H1   = 5'd8;
    localparam logic [4:0] ST_H2   = 5'd9;
    localparam logic [4:0] ST_H3   = 5'd10;
    localparam logic [4:0] ST_D0   = 5'd11;
    localparam logic [4:0] ST_D1   = 5'd12;
    localparam logic [4:0] ST_D2   = 5'd13;
    localparam logic [4:0] ST_D3   = 5'd14;
    localparam logic [4:0] ST_W1   = 5'd15;
    localparam logic [4:0] ST_W2   = 5'd16;
    localparam logic [4:0] ST_W3   = 5'd17;
    localparam logic [4:0] ST_T0   = 5'd18;
    localparam logic [4:0] ST_T1   = 5'd19;
    localparam logic [4:0] ST_N    = 5'd20;
    localparam logic [4:0] ST_G0   = 5'd21;
    localparam logic [4:0] ST_G1   = 5'd22;
    localparam logic [4:0] ST_G2   = 5'd23;
    localparam logic [4:0] ST_G3   = 5'd24;
    localparam logic [4:0] ST_FIN  = 5'd25;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    logic [3:0]  octave_count_reg;
    logic [15:0] lacunarity_reg;
    logic [15:0] persistence_reg;

    logic [7:0]  perm_mem [gn3d_pkg::TABLE_SIZE];
    logic [47:0] grad_mem [gn3d_pkg::TABLE_SIZE];
    logic [7:0]  perm_q_reg;
    logic [47:0] grad_q_reg;
    logic [gn3d_pkg::TABLE_AW-1:0] perm_raddr;

    logic [1:0]  ax_reg;
    logic [2:0]  wi_reg;
    logic [2:0]  c_reg;
    logic [3:0]  oct_reg;
    logic [3:0]  oct_n_reg;
    logic [23:0] coord_reg [3];
    logic [7:0]  base_reg [3];
    logic [15:0] frac_reg [3];
    logic [16:0] w_reg [6];
    logic [16:0] a2_reg;
    logic [16:0] wt_reg;
    logic [16:0] wp_reg;
    logic [31:0] m_reg;
    logic [16:0] g_reg;
    logic signed [35:0] dot_reg;
    logic signed [55:0] sum_reg;
    logic signed [25:0] n_reg;
    logic signed [31:0] total_reg;
    gn3d_pkg::prod_t prod_reg;

    logic               out_valid_reg;
    logic signed [20:0] noise_value_reg;
    logic               is_noise_reg;

    gn3d_pkg::mul_a_t mul_a;
    gn3d_pkg::mul_b_t mul_b;

    logic               in_accept;
    logic               out_free;
    logic [16:0]        a_val;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [17:0] dz;
    logic [16:0]        wx;
    logic [16:0]        wy;
    logic [16:0]        wz;
    logic signed [61:0] rnd16;
    logic signed [63:0] m_tmp;
    logic signed [63:0] a3_tmp;
    logic signed [19:0] w_tmp;
    logic signed [31:0] sat_in;
    logic [3:0]         oct_lim;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign noise_value = noise_value_reg;
    assign is_noise = is_noise_reg;

    assign a_val = wi_reg[0] ? 17'(18'd65536 - {2'b00, frac_reg[wi_reg[2:1]]})
                             : {1'b0, frac_reg[wi_reg[2:1]]};
    assign dx = $signed({2'b00, frac_reg[0]}) - (c_reg[2] ? 18'sd65536 : 18'sd0);
    assign dy = $signed({2'b00, frac_reg[1]}) - (c_reg[1] ? 18'sd65536 : 18'sd0);
    assign dz = $signed({2'b00, frac_reg[2]}) - (c_reg[0] ? 18'sd65536 : 18'sd0);
    assign wx = w_reg[{2'b00, c_reg[2]}];
    assign wy = w_reg[{2'b01, c_reg[1]}];
    assign wz = w_reg[{2'b10, c_reg[0]}];

    assign rnd16 = (prod_reg + 62'sd32768) >>> 16;
    assign m_tmp = (64'(prod_reg) + 64'sd2048) >>> 12;
    assign a3_tmp = (64'(prod_reg) + 64'sd32768) >>> 16;
    assign w_tmp = 20'sd65536 - 20'sd3 * $signed({3'b000, a2_reg})
                 + 20'sd2 * $signed(a3_tmp[19:0]);
    assign sat_in = total_reg;
    assign oct_lim = (octave_count_reg > gn3d_pkg::MAX_OCTAVES) ?
                     gn3d_pkg::MAX_OCTAVES : octave_count_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PMUL:
            begin
                mul_a = {4'b0000, m_reg};
                mul_b = {2'b00, coord_reg[ax_reg]};
            end
            ST_WSQ:
            begin
                mul_a = 36'(a_val);
                mul_b = 26'(a_val);
            end
            ST_WCUB:
            begin
                mul_a = 36'(a2_reg);
                mul_b = 26'(a_val);
            end
            ST_D0:
            begin
                mul_a = 36'(dx);
                mul_b = 26'($signed(grad_q_reg[15:0]));
            end
            ST_D1:
            begin
                mul_a = 36'(dy);
                mul_b = 26'($signed(grad_q_reg[31:16]));
            end
            ST_D2:
            begin
                mul_a = 36'(dz);
                mul_b = 26'($signed(grad_q_reg[47:32]));
            end
            ST_D3:
            begin
                mul_a = 36'(wx);
                mul_b = 26'(wy);
            end
            ST_W2:
            begin
                mul_a = 36'(wt_reg);
                mul_b = 26'(wz);
            end
            ST_T0:
            begin
                mul_a = dot_reg;
                mul_b = 26'(wp_reg);
            end
            ST_G0:
            begin
                mul_a = 36'(n_reg);
                mul_b = 26'(g_reg);
            end
            ST_G1:
            begin
                mul_a = {4'b0000, m_reg};
                mul_b = 26'(lacunarity_reg);
            end
            ST_G2:
            begin
                mul_a = 36'(g_reg);
                mul_b = 26'(persistence_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        perm_raddr = base_reg[2] + 8'(c_reg[0]);
        case (state_reg)
            ST_H1:   perm_raddr = base_reg[1] + 8'(c_reg[1]) + perm_q_reg;
            ST_H2:   perm_raddr = base_reg[0] + 8'(c_reg[2]) + perm_q_reg;
            default: perm_raddr = base_reg[2] + 8'(c_reg[0]);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && op == gn3d_pkg::OP_EVAL)
                begin
                    state_next = (oct_lim == 4'd0) ? ST_FIN : ST_PMUL;
                end
            end
            ST_PMUL: state_next = ST_PSAV;
            ST_PSAV: state_next = (ax_reg == 2'd2) ? ST_WSQ : ST_PMUL;
            ST_WSQ:  state_next = ST_WA2;
            ST_WA2:  state_next = ST_WCUB;
            ST_WCUB: state_next = ST_WSAV;
            ST_WSAV: state_next = (wi_reg == 3'd5) ? ST_H0 : ST_WSQ;
            ST_H0:   state_next = ST_H1;
            ST_H1:   state_next = ST_H2;
            ST_H2:   state_next = ST_H3;
            ST_H3:   state_next = ST_D0;
            ST_D0:   state_next = ST_D1;
            ST_D1:   state_next = ST_D2;
            ST_D2:   state_next = ST_D3;
            ST_D3:   state_next = ST_W1;
            ST_W1:   state_next = ST_W2;
            ST_W2:   state_next = ST_W3;
            ST_W3:   state_next = ST_T0;
            ST_T0:   state_next = ST_T1;
            ST_T1:   state_next = (c_reg == 3'd7) ? ST_N : ST_H0;
            ST_N:    state_next = ST_G0;
            ST_G0:   state_next = ST_G1;
            ST_G1:   state_next = ST_G2;
            ST_G2:   state_next = ST_G3;
            ST_G3:   state_next = (oct_reg + 4'd1 == oct_n_reg) ? ST_FIN : ST_PMUL;
            ST_FIN:  state_next = out_free ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            octave_count_reg <= gn3d_pkg::RST_OCTAVES;
            lacunarity_reg <= gn3d_pkg::RST_LACUNARITY;
            persistence_reg <= gn3d_pkg::RST_PERSISTENCE;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    gn3d_pkg::REG_OCTAVES:     octave_count_reg <= cfg_data[3:0];
                    gn3d_pkg::REG_LACUNARITY:  lacunarity_reg <= cfg_data;
                    gn3d_pkg::REG_PERSISTENCE: persistence_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_accept && op != gn3d_pkg::OP_EVAL)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        perm_q_reg <= perm_mem[perm_raddr];
        if (state_reg == ST_H3)
        begin
            grad_q_reg <= grad_mem[perm_q_reg];
        end
        if (in_accept && op == gn3d_pkg::OP_PERM)
        begin
            perm_mem[entry_index] <= perm_value;
        end
        if (in_accept && op == gn3d_pkg::OP_GRAD)
        begin
            grad_mem[entry_index] <= {grad_z, grad_y, grad_x};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                coord_reg[0] <= coord_x;
                coord_reg[1] <= coord_y;
                coord_reg[2] <= coord_z;
                m_reg <= 32'd65536;
                g_reg <= 17'd65536;
                total_reg <= '0;
                sum_reg <= '0;
                ax_reg <= '0;
                wi_reg <= '0;
                c_reg <= '0;
                oct_reg <= '0;
                oct_n_reg <= oct_lim;
                if (in_accept && op != gn3d_pkg::OP_EVAL)
                begin
                    noise_value_reg <= '0;
                    is_noise_reg <= 1'b0;
                end
            end
            ST_PSAV:
            begin
                base_reg[ax_reg] <= prod_reg[39:32];
                frac_reg[ax_reg] <= prod_reg[31:16];
                ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
            end
            ST_WA2:
            begin
                a2_reg <= a3_tmp[16:0];
            end
            ST_WSAV:
            begin
                w_reg[wi_reg] <= (w_tmp < 0) ? 17'd0 : w_tmp[16:0];
                wi_reg <= (wi_reg == 3'd5) ? 3'd0 : wi_reg + 3'd1;
            end
            ST_D1:
            begin
                dot_reg <= 36'(prod_reg);
            end
            ST_D2, ST_D3:
            begin
                dot_reg <= dot_reg + 36'(prod_reg);
            end
            ST_W1:
            begin
                wt_reg <= rnd16[16:0];
            end
            ST_W3:
            begin
                wp_reg <= rnd16[16:0];
            end
            ST_T1:
            begin
                sum_reg <= sum_reg + 56'(prod_reg);
                c_reg <= c_reg + 3'd1;
            end
            ST_N:
            begin
                n_reg <= 26'(gn3d_pkg::round_shift(64'(sum_reg), 30));
            end
            ST_G1:
            begin
                total_reg <= total_reg + 32'(gn3d_pkg::round_shift(64'(prod_reg), 16));
            end
            ST_G2:
            begin
                m_reg <= (m_tmp > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : m_tmp[31:0];
            end
            ST_G3:
            begin
                g_reg <= a3_tmp[16:0];
                oct_reg <= oct_reg + 4'd1;
                sum_reg <= '0;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    is_noise_reg <= 1'b1;
                    if (sat_in > gn3d_pkg::NOISE_MAX)
                    begin
                        noise_value_reg <= gn3d_pkg::NOISE_MAX[20:0];
                    end
                    else if (sat_in < gn3d_pkg::NOISE_MIN)
                    begin
                        noise_value_reg <= gn3d_pkg::NOISE_MIN[20:0];
                    end
                    else
                    begin
                        noise_value_reg <= sat_in[20:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && op != gn3d_pkg::OP_EVAL |=> out_valid && !is_noise)
        else $error("load request not acknowledged");

    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_noise |-> noise_value == 21'sd0)
        else $error("load acknowledgment carries nonzero value");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("request accepted while sequencer busy");

    a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_N |-> c_reg == 3'd0 && $past(c_reg) == 3'd7)
        else $error("octave sum taken before all corners");

endmodule
